@@ design/fscp_pkg.sv @@
// Shared constants and types for the first-seen color palette.
// No dependencies; imported by the palette top, fscp_lcg and the bench.
package fscp_pkg;

	// Default width of the color index used for lookups.
	localparam int INDEX_BITS_DEF = 8;

	// Generator constants: state = MUL * state + ADD, modulo 2^32.
	localparam logic [31:0] LCG_MUL  = 32'd1664525;
	localparam logic [31:0] LCG_ADD  = 32'd1013904223;
	localparam logic [31:0] LCG_SEED = 32'd42;

	// Configuration register map.
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_ADDR_W-1:0] REG_WHITE_INDEX = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BLACK_INDEX = 1'd1;

	// Reset values of the configuration registers.
	localparam logic [CFG_DATA_W-1:0] WHITE_RESET = 8'd0;
	localparam logic [CFG_DATA_W-1:0] BLACK_RESET = 8'd1;

	localparam logic [23:0] RGB_WHITE = 24'hFFFFFF;
	localparam logic [23:0] RGB_BLACK = 24'h000000;

	// Frame tags stored beside each color. An entry counts as seen when its
	// tag equals the tag of the current frame; zero is the cleared tag and is
	// never used by a frame.
	localparam int EPOCH_BITS = 16;
	localparam logic [EPOCH_BITS-1:0] EPOCH_CLEARED = '0;
	localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST   = EPOCH_BITS'(1);
	localparam logic [EPOCH_BITS-1:0] EPOCH_LAST    = '1;

	// One palette memory entry.
	typedef struct packed {
		logic [EPOCH_BITS-1:0] epoch;
		logic [23:0]           rgb;
	} palette_entry_t;

	// How the color of an item in flight is produced.
	typedef enum logic [1:0] {
		KIND_BLACK,
		KIND_WHITE,
		KIND_HIT,
		KIND_NEW
	} color_kind_t;

	// Generator control for one item.
	typedef struct packed {
		logic reseed;
		logic step;
	} lcg_ctrl_t;

endpackage

@@ design/first_seen_color_palette.sv @@
// Top level of the first-seen color palette: index-to-RGB stream mapper.
// Depends on fscp_pkg and fscp_lcg.
//
//   channel   dir  payload (low bit first)                  handshake
//   s_*       in   tdata: color_index[7:0]; tuser: new_frame  tvalid/tready
//   m_*       out  tdata: red[7:0] green[15:8] blue[23:16]     tvalid/tready
//   cfg_*     in   wdata: register value, addr: register      wr_en, no wait
//
// One item per cycle unless a clearing pass runs or a stalled output holds the
// stage and blocks the input. Results appear the cycle after acceptance, from
// the palette memory's registered read. Entries hold a color and the frame tag
// it was made in; tag test, generator step and write-back happen in the result
// cycle, with a same-edge write forwarded to the next lookup of that index.
// After reset (async, active low) clearing all DEPTH entries holds s_tready low;
// it runs again when frame tags run out (about every 65534 frames).
module first_seen_color_palette
	import fscp_pkg::*;
#(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// slave side
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] color_index
	input  logic [0:0]            s_tuser,   // [0] new_frame
	// master side
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
	// configuration
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int DEPTH = 1 << INDEX_BITS;

	logic [CFG_DATA_W-1:0] white_q;
	logic [CFG_DATA_W-1:0] black_q;

	palette_entry_t        color_mem [DEPTH];
	palette_entry_t        rdata_q;

	logic                  clr_busy_q;
	logic [INDEX_BITS-1:0] clr_addr_q;
	logic [EPOCH_BITS-1:0] epoch_q;

	logic                  valid_s1;
	logic [INDEX_BITS-1:0] idx_s1;
	logic                  new_frame_s1;
	logic [EPOCH_BITS-1:0] epoch_s1;
	logic                  fwd_s1;
	palette_entry_t        fwd_entry_s1;

	logic                  accept;
	logic                  leave;
	logic                  new_frame;
	logic [INDEX_BITS-1:0] idx;
	logic                  wrap_wait;
	logic                  clr_start;
	logic [EPOCH_BITS-1:0] epoch_next;
	palette_entry_t        entry;
	logic                  is_black;
	logic                  is_white;
	logic                  seen;
	logic                  miss;
	logic                  mem_wr;
	color_kind_t           kind;
	lcg_ctrl_t             lcg_ctrl;
	logic [31:0]           lcg_next;
	logic [23:0]           new_color;
	logic [23:0]           rgb;

	// ---- configuration registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_q <= WHITE_RESET;
			black_q <= BLACK_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_WHITE_INDEX: white_q <= cfg_wdata;
				REG_BLACK_INDEX: black_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---- accept side ----
	assign new_frame = s_tuser[0];
	assign idx       = INDEX_BITS'(s_tdata);
	assign leave     = valid_s1 && m_tready;

	// A new frame on the last tag must wait for a clearing pass; the pass
	// starts once the result stage is empty so no late write survives it.
	assign wrap_wait = s_tvalid && new_frame && (epoch_q == EPOCH_LAST);
	assign clr_start = wrap_wait && !valid_s1;

	assign s_tready  = !clr_busy_q && !wrap_wait && (!valid_s1 || m_tready);
	assign accept    = s_tvalid && s_tready;

	// A new frame moves to a fresh tag ahead of this item's lookup.
	assign epoch_next = new_frame ? epoch_q + EPOCH_BITS'(1) : epoch_q;

	// ---- frame tag and clearing pass ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			epoch_q    <= EPOCH_FIRST;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + INDEX_BITS'(1);
			if (clr_addr_q == INDEX_BITS'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
				epoch_q    <= EPOCH_FIRST;
			end
		end else if (clr_start) begin
			clr_busy_q <= 1'b1;
		end else if (accept) begin
			epoch_q <= epoch_next;
		end
	end

	// ---- result stage decode ----
	// The entry written by the previous item at this item's read edge is
	// forwarded in place of the stale read data.
	assign entry    = fwd_s1 ? fwd_entry_s1 : rdata_q;

	// Black beats white when both registers name the same index.
	assign is_black = idx_s1 == INDEX_BITS'(black_q);
	assign is_white = idx_s1 == INDEX_BITS'(white_q);
	assign seen     = entry.epoch == epoch_s1;
	assign miss     = !is_black && !is_white && !seen;

	always_comb begin
		if (is_black) begin
			kind = KIND_BLACK;
		end else if (is_white) begin
			kind = KIND_WHITE;
		end else if (seen) begin
			kind = KIND_HIT;
		end else begin
			kind = KIND_NEW;
		end
	end

	// Reseed is held while a new-frame item waits; the state only moves on.
	assign lcg_ctrl.reseed = valid_s1 && new_frame_s1;
	assign lcg_ctrl.step   = leave && miss;

	fscp_lcg u_lcg (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (lcg_ctrl),
		.next_state (lcg_next)
	);

	// Bytes 3, 2, 1 of the stepped state give red, green, blue.
	assign new_color = lcg_next[31:8];
	assign mem_wr    = lcg_ctrl.step;

	// ---- palette memory: clear during a pass, read on accept, write back on a miss ----
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			color_mem[clr_addr_q] <= {EPOCH_CLEARED, RGB_BLACK};
		end else if (mem_wr) begin
			color_mem[idx_s1] <= {epoch_s1, new_color};
		end
		if (accept) begin
			rdata_q <= color_mem[idx];
		end
	end

	// ---- result stage ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (leave) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1       <= idx;
			new_frame_s1 <= new_frame;
			epoch_s1     <= epoch_next;
			fwd_s1       <= mem_wr && (idx_s1 == idx);
			fwd_entry_s1 <= {epoch_s1, new_color};
		end
	end

	always_comb begin
		unique case (kind)
			KIND_BLACK: rgb = RGB_BLACK;
			KIND_WHITE: rgb = RGB_WHITE;
			KIND_HIT:   rgb = entry.rgb;
			KIND_NEW:   rgb = new_color;
			default:    rgb = RGB_BLACK;
		endcase
	end

	assign m_tvalid = valid_s1;
	assign m_tdata  = {rgb[7:0], rgb[15:8], rgb[23:16]};

endmodule

@@ design/fscp_lcg.sv @@
// 32-bit LCG with reseed, one step per cycle while ctrl.step is set.
// Depends on fscp_pkg.
module fscp_lcg
	import fscp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  lcg_ctrl_t   ctrl,
	output logic [31:0] next_state
);

	logic [31:0] state_q;
	logic [31:0] base;

	// Reseed takes effect before the step of the same item.
	assign base       = ctrl.reseed ? LCG_SEED : state_q;
	assign next_state = base * LCG_MUL + LCG_ADD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LCG_SEED;
		end else if (ctrl.step) begin
			state_q <= next_state;
		end else if (ctrl.reseed) begin
			state_q <= LCG_SEED;
		end
	end

endmodule

@@ design/fscp_checker.sv @@
// Port-level checks for the first-seen color palette, bound to the top.
// Depends on first_seen_color_palette.
module fscp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// A held result keeps its color.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Every accepted item shows up on the output the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted item not presented");

	// A result is either freshly accepted or still held from a stall.
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $past(s_tvalid && s_tready) || $past(m_tvalid && !m_tready))
		else $error("result without an accepted item");

	// A stalled output blocks the input.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

endmodule

bind first_seen_color_palette fscp_checker u_fscp_checker (.*);

@@ tb/tb_first_seen_color_palette.sv @@
`timescale 1ns / 100ps
// Self-checking bench for first_seen_color_palette: drives pixel indices, mirrors the
// palette (seen bits, remembered colors, generator) and checks every RGB item out.
// Depends on fscp_pkg and the block's RTL only.
module tb_first_seen_color_palette;
	import fscp_pkg::*;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_rgb_t;

	typedef struct {
		logic [7:0] color_index;
		logic       new_frame;
	} pixel_item_t;

	localparam int IDX_DEPTH = 1 << INDEX_BITS_DEF;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata   = '0;   // [7:0] color_index
	logic [0:0]            s_tuser   = '0;   // [0] new_frame
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [23:0]           m_tdata;          // [7:0] red, [15:8] green, [23:16] blue
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = REG_WHITE_INDEX;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// pixels waiting for the driver, colors waiting for the output side
	pixel_item_t pixels_to_send[$];
	pixel_rgb_t  colors_due[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches    = 0;

	// Mirror of the palette. palette_mem is only read behind a set seen bit,
	// so entries never written are never looked at.
	logic        seen_bits   [IDX_DEPTH];
	logic [23:0] palette_mem [IDX_DEPTH];
	logic [31:0] lcg_now;
	logic [7:0]  white_sel;
	logic [7:0]  black_sel;

	first_seen_color_palette #(
		.INDEX_BITS(INDEX_BITS_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Color of one accepted pixel; updates the mirror the way the block should.
	// Black is checked before white, so black wins when both registers match.
	// White/black hits neither step the generator nor set a seen bit.
	function automatic pixel_rgb_t palette_lookup(logic [7:0] idx, logic frame_start);
		pixel_rgb_t  c;
		logic [23:0] rgb;
		if (frame_start) begin
			foreach (seen_bits[i])
				seen_bits[i] = 1'b0;
			lcg_now = LCG_SEED;
		end
		if (idx == black_sel) begin
			rgb = RGB_BLACK;
		end else if (idx == white_sel) begin
			rgb = RGB_WHITE;
		end else if (seen_bits[idx]) begin
			rgb = palette_mem[idx];
		end else begin
			// first sighting in this frame: step the generator, keep bytes 3..1
			lcg_now = lcg_now * LCG_MUL + LCG_ADD;
			rgb = lcg_now[31:8];
			palette_mem[idx] = rgb;
			seen_bits[idx] = 1'b1;
		end
		c.red   = rgb[23:16];
		c.green = rgb[15:8];
		c.blue  = rgb[7:0];
		return c;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %02h actual %02h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Driver: a presented item stays put until taken; then the next one from
	// the queue goes out, unless this cycle is picked as an idle one.
	always @(posedge clk) begin
		pixel_item_t nxt;
		if (arst_n) begin
			if (!s_tvalid || s_tready) begin
				if (s_tvalid)
					colors_due.push_back(palette_lookup(s_tdata, s_tuser[0]));
				if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pixels_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.color_index;
					s_tuser  <= nxt.new_frame;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random backpressure, and each taken item checked field by field
	// against the oldest predicted color.
	always @(posedge clk) begin
		pixel_rgb_t want;
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (m_tvalid && m_tready) begin
				if (colors_due.size() == 0) begin
					$display("%0t: unexpected item, expected none actual %06h", $time, m_tdata);
					mismatches++;
				end else begin
					want = colors_due.pop_front();
					check_field("red",   want.red,   m_tdata[7:0]);
					check_field("green", want.green, m_tdata[15:8]);
					check_field("blue",  want.blue,  m_tdata[23:16]);
				end
			end
		end
	end

	task automatic queue_pixel(logic [7:0] idx, logic frame_start);
		pixel_item_t p;
		p.color_index = idx;
		p.new_frame   = frame_start;
		pixels_to_send.push_back(p);
	endtask

	// Wait until every pixel is in and every color is out, then let the pipeline settle.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pixels_to_send.size() != 0 || s_tvalid || colors_due.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Only called with the block idle, so the mirror can take the new values
	// at once.
	task automatic set_palette_regs(logic [7:0] white_val, logic [7:0] black_val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= REG_WHITE_INDEX;
		cfg_wdata <= white_val;
		@(posedge clk);
		cfg_addr  <= REG_BLACK_INDEX;
		cfg_wdata <= black_val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		white_sel = white_val;
		black_sel = black_val;
	endtask

	// Mostly frames that open with new_frame and reuse a small pool of indices,
	// so hits and first sightings mix; some frames carry on without a reseed,
	// a few new_frame flags land mid-frame, and some pixels use the whole range.
	task automatic queue_random_pixels(int count);
		int         left;
		int         frame_len;
		int         pool;
		int         pick;
		logic [7:0] idx;
		logic       frame_start;
		left = count;
		while (left > 0) begin
			frame_len = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(80, 4);
			pool = ($urandom_range(3) == 0) ? 255 : $urandom_range(40, 3);
			for (int k = 0; k < frame_len && left > 0; k++) begin
				pick = $urandom_range(99);
				if (pick < 6)
					idx = white_sel;
				else if (pick < 12)
					idx = black_sel;
				else if (pick < 70)
					idx = 8'($urandom_range(pool));
				else
					idx = 8'($urandom_range(255));
				if (k == 0)
					frame_start = ($urandom_range(9) != 0);
				else
					frame_start = ($urandom_range(199) == 0);
				queue_pixel(idx, frame_start);
				left--;
			end
		end
	endtask

	initial begin
		foreach (seen_bits[i])
			seen_bits[i] = 1'b0;
		lcg_now   = LCG_SEED;
		white_sel = WHITE_RESET;
		black_sel = BLACK_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 33;
		recv_idle_pct = 66;

		// Reset register values: white 0, black 1.
		queue_pixel(8'd0, 1'b0);     // white
		queue_pixel(8'd1, 1'b0);     // black
		queue_pixel(8'd2, 1'b0);     // first color from the seed
		queue_pixel(8'hFF, 1'b0);
		queue_pixel(8'd2, 1'b0);     // remembered
		queue_pixel(8'hFF, 1'b0);    // remembered
		queue_pixel(8'h80, 1'b0);
		queue_pixel(8'h7F, 1'b0);
		queue_pixel(8'h55, 1'b0);
		queue_pixel(8'hAA, 1'b0);
		queue_pixel(8'd2, 1'b1);     // reseed, so same color as the first one
		queue_pixel(8'd0, 1'b1);     // reseed on a white pixel, no step
		queue_pixel(8'd2, 1'b0);     // new again in the fresh frame
		queue_pixel(8'd1, 1'b1);     // reseed on a black pixel
		queue_pixel(8'd3, 1'b0);
		wait_idle();

		// Registers move onto index 3, remembered in this frame, and index 2:
		// white and black take priority, the old entries stay.
		set_palette_regs(8'd2, 8'd3);
		queue_pixel(8'd2, 1'b0);
		queue_pixel(8'd3, 1'b0);
		queue_pixel(8'd0, 1'b0);     // no longer white, gets a color
		queue_pixel(8'd1, 1'b0);     // no longer black, gets a color
		wait_idle();

		// Same index in both registers; index 3 falls back to its entry, 2 is new.
		set_palette_regs(8'd5, 8'd5);
		queue_pixel(8'd5, 1'b0);     // black wins
		queue_pixel(8'd2, 1'b0);
		queue_pixel(8'd3, 1'b0);
		wait_idle();

		// Random part, register extremes first, sender idling less.
		set_palette_regs(8'hFF, 8'h00);
		queue_random_pixels(440);
		wait_idle();

		set_palette_regs(8'($urandom_range(255)), 8'($urandom_range(255)));
		send_idle_pct = 66;
		recv_idle_pct = 33;
		queue_random_pixels(440);
		wait_idle();

		// Back to back on both sides, opposite extremes.
		set_palette_regs(8'h00, 8'hFF);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_pixels(440);
		wait_idle();

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Hang guard, far beyond the slowest correct run.
	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ first_seen_color_palette.f @@
design/fscp_pkg.sv
design/fscp_lcg.sv
design/first_seen_color_palette.sv
design/fscp_checker.sv
tb/tb_first_seen_color_palette.sv
